// ===== design/pfxd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfxd_pkg
// Shared constants, types and helpers for the prefix code bit decoder.
// ----------------------------------------------------------------------------
package pfxd_pkg;

  // table geometry and code limits
  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_CODE_LEN  = 32;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int BYTE_W = 8;

  // derived widths
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int ACC_W   = MAX_CODE_LEN;
  localparam int CNT_W   = $clog2(MAX_CODE_LEN + 2);
  localparam int CMP_W   = (ACC_W > CODE_W) ? ACC_W : CODE_W;
  localparam int BITS_W  = $clog2(BYTE_W + 1);
  localparam int ENTRY_W = SYM_W + LEN_W + CODE_W;

  // item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // result kinds
  localparam logic KIND_SYMBOL   = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  // one code table entry as held in the ram
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_entry_t;

  // sweep control towards the match unit
  typedef struct packed {
    logic clr;
    logic cmp;
  } match_ctrl_t;

  // sweep outcome from the match unit
  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] longest;
  } match_stat_t;

  // ones in the low len bits of a code word
  function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    if (32'(len) >= CODE_W) begin
      m = '1;
    end else begin
      m = (CODE_W'(1) << len) - CODE_W'(1);
    end
    return m;
  endfunction

endpackage

// ===== design/pfxd_ifs.sv =====
// ----------------------------------------------------------------------------
// pfxd channel interfaces
// Valid/ready channels for decoder items and decoder results.
// ----------------------------------------------------------------------------

// input items: table loads, data bytes and table clears
interface pfxd_in_if;
  logic                         valid;
  logic                         ready;
  logic [pfxd_pkg::OP_W-1:0]    opcode;
  logic [7:0]                   entry_index;
  logic [pfxd_pkg::SYM_W-1:0]   entry_symbol;
  logic [pfxd_pkg::LEN_W-1:0]   entry_length;
  logic [pfxd_pkg::CODE_W-1:0]  entry_code;
  logic [pfxd_pkg::BYTE_W-1:0]  data_byte;

  modport source (
    output valid, opcode, entry_index, entry_symbol, entry_length, entry_code,
           data_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, entry_symbol, entry_length, entry_code,
           data_byte,
    output ready
  );
endinterface

// result items: decoded symbols and overflow errors
interface pfxd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [pfxd_pkg::SYM_W-1:0] symbol;
  logic                       last;

  modport source (
    output valid, kind, symbol, last,
    input  ready
  );
  modport sink (
    input  valid, kind, symbol, last,
    output ready
  );
endinterface

// ===== design/prefix_code_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// prefix_code_bit_decoder
// Bit serial decoder for a prefix coded byte stream with a loadable code table.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   opcode, entry_index, entry_symbol, entry_length,
//                              entry_code, data_byte
//  out_ch   out  valid/ready   kind, symbol, last
//
// Load and clear items are done in the idle state. A data byte is fed to the
// accumulator bit by bit: each coded bit sweeps the whole table through the
// single ram port, one entry a cycle, then drains the last read and decides.
// Reset clears the table valid bits, the accumulator and the bit count at once;
// no clearing pass is needed.
// A full output register with a result already pending stalls the sweep at
// the decision step; one new item is taken only when the previous one is done.
// ----------------------------------------------------------------------------
module prefix_code_bit_decoder (
  input  logic       clk,
  input  logic       rst_n,
  pfxd_in_if.sink    in_ch,
  pfxd_out_if.source out_ch
);

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SHIFT  = 6'b000010,
    ST_SWEEP  = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_FLUSH  = 6'b100000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [pfxd_pkg::BYTE_W-1:0]         sreg_r, sreg_nxt;
  logic [pfxd_pkg::BITS_W-1:0]         bits_left_r, bits_left_nxt;
  logic [pfxd_pkg::ACC_W-1:0]          acc_r, acc_nxt;
  logic [pfxd_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [pfxd_pkg::IDX_W-1:0]          addr_r, addr_nxt;
  logic [pfxd_pkg::TABLE_ENTRIES-1:0]  valid_r, valid_nxt;
  logic                                rd_pend_r;
  logic                                rd_vld_r;
  logic                                pend_v_r, pend_v_nxt;
  logic                                pend_kind_r, pend_kind_nxt;
  logic [pfxd_pkg::SYM_W-1:0]          pend_sym_r, pend_sym_nxt;
  logic                                out_v_r, out_v_nxt;
  logic                                out_kind_r, out_kind_nxt;
  logic [pfxd_pkg::SYM_W-1:0]          out_sym_r, out_sym_nxt;
  logic                                out_last_r, out_last_nxt;

  logic                                in_xfer;
  logic                                out_free;
  logic                                ram_we;
  logic [pfxd_pkg::IDX_W-1:0]          ram_addr;
  logic [pfxd_pkg::IDX_W-1:0]          load_idx;
  logic                                load_ok;
  logic [pfxd_pkg::LEN_W-1:0]          load_len;
  pfxd_pkg::tbl_entry_t                ram_wdata;
  pfxd_pkg::tbl_entry_t                ram_rdata;
  pfxd_pkg::match_ctrl_t               mctrl;
  pfxd_pkg::match_stat_t               mstat;
  logic                                res_v;
  logic                                res_kind;
  logic [pfxd_pkg::SYM_W-1:0]          res_sym;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_v_r || out_ch.ready;

  // table write: slot range check, over-long lengths set to zero and code trim
  assign load_ok  = (32'(in_ch.entry_index) < pfxd_pkg::TABLE_ENTRIES);
  assign load_idx = in_ch.entry_index[pfxd_pkg::IDX_W-1:0];
  assign load_len = (32'(in_ch.entry_length) > pfxd_pkg::MAX_CODE_LEN) ?
                    '0 : in_ch.entry_length;
  assign ram_wdata.sym  = in_ch.entry_symbol;
  assign ram_wdata.len  = load_len;
  assign ram_wdata.code = in_ch.entry_code & pfxd_pkg::code_mask(load_len);
  assign ram_we   = in_xfer && (in_ch.opcode == pfxd_pkg::OP_LOAD) && load_ok;
  assign ram_addr = (state_r == ST_IDLE) ? load_idx : addr_r;

  pfxd_ram #(
    .WIDTH (pfxd_pkg::ENTRY_W),
    .DEPTH (pfxd_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // match unit sees the read data in the cycle after each issued address
  assign mctrl.clr = (state_r == ST_SHIFT);
  assign mctrl.cmp = rd_pend_r;

  pfxd_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mctrl),
    .entry     (ram_rdata),
    .entry_vld (rd_vld_r),
    .acc       (acc_r),
    .cnt       (cnt_r),
    .stat      (mstat)
  );

  // outcome of the sweep for the current bit
  always_comb begin
    res_v    = 1'b0;
    res_kind = pfxd_pkg::KIND_SYMBOL;
    res_sym  = '0;
    if (mstat.hit) begin
      res_v    = 1'b1;
      res_sym  = mstat.sym;
    end else if (32'(cnt_r) > 32'(mstat.longest)) begin
      res_v    = 1'b1;
      res_kind = pfxd_pkg::KIND_OVERFLOW;
    end
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    sreg_nxt      = sreg_r;
    bits_left_nxt = bits_left_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    valid_nxt     = valid_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_sym_nxt  = pend_sym_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (pfxd_pkg::op_t'(in_ch.opcode))
            pfxd_pkg::OP_LOAD: begin
              if (load_ok) begin
                valid_nxt[load_idx] = 1'b1;
              end
            end
            pfxd_pkg::OP_DATA: begin
              sreg_nxt      = in_ch.data_byte;
              bits_left_nxt = pfxd_pkg::BITS_W'(pfxd_pkg::BYTE_W);
              state_nxt     = ST_SHIFT;
            end
            pfxd_pkg::OP_CLEAR: begin
              valid_nxt = '0;
              acc_nxt   = '0;
              cnt_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        acc_nxt   = {acc_r[pfxd_pkg::ACC_W-2:0], sreg_r[pfxd_pkg::BYTE_W-1]};
        sreg_nxt  = {sreg_r[pfxd_pkg::BYTE_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + pfxd_pkg::CNT_W'(1);
        addr_nxt  = '0;
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        addr_nxt = addr_r + pfxd_pkg::IDX_W'(1);
        if (addr_r == pfxd_pkg::IDX_W'(pfxd_pkg::TABLE_ENTRIES - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!(res_v && pend_v_r && !out_free)) begin
          if (res_v) begin
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_kind_nxt = pend_kind_r;
              out_sym_nxt  = pend_sym_r;
              out_last_nxt = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_kind_nxt = res_kind;
            pend_sym_nxt  = res_sym;
            acc_nxt       = '0;
            cnt_nxt       = '0;
          end
          bits_left_nxt = bits_left_r - pfxd_pkg::BITS_W'(1);
          state_nxt     = (bits_left_r == pfxd_pkg::BITS_W'(1)) ? ST_FLUSH : ST_SHIFT;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_kind_nxt = pend_kind_r;
          out_sym_nxt  = pend_sym_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      acc_r     <= '0;
      cnt_r     <= '0;
      valid_r   <= '0;
      rd_pend_r <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      valid_r   <= valid_nxt;
      rd_pend_r <= (state_r == ST_SWEEP);
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // payload and sweep bookkeeping
  always_ff @(posedge clk) begin
    sreg_r      <= sreg_nxt;
    bits_left_r <= bits_left_nxt;
    addr_r      <= addr_nxt;
    rd_vld_r    <= valid_r[addr_r];
    pend_kind_r <= pend_kind_nxt;
    pend_sym_r  <= pend_sym_nxt;
    out_kind_r  <= out_kind_nxt;
    out_sym_r   <= out_sym_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.kind   = out_kind_r;
  assign out_ch.symbol = out_sym_r;
  assign out_ch.last   = out_last_r;

endmodule

// ===== design/pfxd_ram.sv =====
// ----------------------------------------------------------------------------
// pfxd_ram
// Generic single port ram with registered read data.
// ----------------------------------------------------------------------------
module pfxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/pfxd_match.sv =====
// ----------------------------------------------------------------------------
// pfxd_match
// Compares one table entry per cycle against the bit accumulator, keeps the
// first hit of the sweep and the longest code length seen.
// ----------------------------------------------------------------------------
module pfxd_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfxd_pkg::match_ctrl_t         ctrl,
  input  pfxd_pkg::tbl_entry_t          entry,
  input  logic                          entry_vld,
  input  logic [pfxd_pkg::ACC_W-1:0]    acc,
  input  logic [pfxd_pkg::CNT_W-1:0]    cnt,
  output pfxd_pkg::match_stat_t         stat
);

  logic                          hit_r, hit_nxt;
  logic [pfxd_pkg::SYM_W-1:0]    sym_r, sym_nxt;
  logic [pfxd_pkg::LEN_W-1:0]    longest_r, longest_nxt;
  logic [pfxd_pkg::LEN_W-1:0]    eff_len;
  logic                          code_eq;

  // an entry that was never loaded since the last clear counts as unused
  assign eff_len = entry_vld ? entry.len : '0;
  assign code_eq = (pfxd_pkg::CMP_W'(entry.code) == pfxd_pkg::CMP_W'(acc));

  // first hit in index order wins, longest length tracked alongside
  always_comb begin
    hit_nxt     = hit_r;
    sym_nxt     = sym_r;
    longest_nxt = longest_r;
    if (ctrl.clr) begin
      hit_nxt     = 1'b0;
      longest_nxt = '0;
    end else if (ctrl.cmp) begin
      if (eff_len > longest_r) begin
        longest_nxt = eff_len;
      end
      if (!hit_r && (eff_len != '0) && (32'(eff_len) == 32'(cnt)) && code_eq) begin
        hit_nxt = 1'b1;
        sym_nxt = entry.sym;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r     <= 1'b0;
      longest_r <= '0;
    end else begin
      hit_r     <= hit_nxt;
      longest_r <= longest_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

  assign stat.hit     = hit_r;
  assign stat.sym     = sym_r;
  assign stat.longest = longest_r;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the prefix code bit decoder. Directed tests cover an
// empty table, lowest-index priority, stray and over-long codes, 32-bit codes
// and unused slots. Random sessions then load prefix code trees and send
// streams built from their codes, mixed with noise, under four handshake
// idling phases. Every result transfer is checked against a local decoder.
// ----------------------------------------------------------------------------
module tb_top;

  // opcode that the decoder ignores
  localparam logic [pfxd_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;
  // cycles a data byte may keep the decoder busy
  localparam int BYTE_CYCLES = 8 * (pfxd_pkg::TABLE_ENTRIES + 3) + 16;

  typedef struct packed {
    logic [pfxd_pkg::OP_W-1:0]   op;
    logic [7:0]                  index;
    logic [pfxd_pkg::SYM_W-1:0]  symbol;
    logic [pfxd_pkg::LEN_W-1:0]  length;
    logic [pfxd_pkg::CODE_W-1:0] code;
    logic [pfxd_pkg::BYTE_W-1:0] data;
  } dec_item_t;

  typedef struct packed {
    logic                       kind;
    logic [pfxd_pkg::SYM_W-1:0] symbol;
    logic                       last;
  } dec_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pfxd_in_if  in_ch ();
  pfxd_out_if out_ch ();

  prefix_code_bit_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the decoder state
  logic [pfxd_pkg::SYM_W-1:0] ct_sym  [pfxd_pkg::TABLE_ENTRIES];
  int                         ct_len  [pfxd_pkg::TABLE_ENTRIES];
  logic [63:0]                ct_code [pfxd_pkg::TABLE_ENTRIES];
  logic [63:0]                acc_bits;
  int                         acc_count;

  dec_result_t pending_results[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_code_table();
    for (int i = 0; i < pfxd_pkg::TABLE_ENTRIES; i++) begin
      ct_sym[i]  = '0;
      ct_len[i]  = 0;
      ct_code[i] = '0;
    end
    acc_bits  = '0;
    acc_count = 0;
  endtask

  // work out the results of one accepted item and queue them
  task automatic decode_item(input dec_item_t it);
    dec_result_t res[$];
    dec_result_t r;
    int          len;
    int          longest;
    bit          hit;
    case (it.op)
      pfxd_pkg::OP_LOAD: begin
        if (it.index < pfxd_pkg::TABLE_ENTRIES) begin
          len = it.length;
          if (len > pfxd_pkg::MAX_CODE_LEN) len = 0;
          ct_sym[it.index] = it.symbol;
          ct_len[it.index] = len;
          if (len == 0) ct_code[it.index] = '0;
          else if (len >= 64) ct_code[it.index] = 64'(it.code);
          else ct_code[it.index] = 64'(it.code) & ((64'd1 << len) - 64'd1);
        end
      end
      pfxd_pkg::OP_CLEAR: clear_code_table();
      pfxd_pkg::OP_DATA: begin
        longest = 0;
        for (int i = 0; i < pfxd_pkg::TABLE_ENTRIES; i++)
          if (ct_len[i] > longest) longest = ct_len[i];
        for (int b = 7; b >= 0; b--) begin
          acc_bits = (acc_bits << 1) | 64'(it.data[b]);
          acc_count++;
          r.last = 1'b0;
          if (acc_count > longest) begin
            r.kind   = pfxd_pkg::KIND_OVERFLOW;
            r.symbol = '0;
            res.push_back(r);
            acc_bits  = '0;
            acc_count = 0;
          end else begin
            hit = 1'b0;
            for (int i = 0; i < pfxd_pkg::TABLE_ENTRIES && !hit; i++) begin
              if (ct_len[i] != 0 && ct_len[i] == acc_count && ct_code[i] == acc_bits) begin
                r.kind   = pfxd_pkg::KIND_SYMBOL;
                r.symbol = ct_sym[i];
                res.push_back(r);
                hit = 1'b1;
              end
            end
            if (hit) begin
              acc_bits  = '0;
              acc_count = 0;
            end
          end
        end
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  // random item of one opcode, all other fields random
  function automatic dec_item_t random_item(input logic [pfxd_pkg::OP_W-1:0] op);
    dec_item_t it;
    it.op     = op;
    it.index  = 8'($urandom_range(255));
    it.symbol = pfxd_pkg::SYM_W'($urandom_range(255));
    it.length = pfxd_pkg::LEN_W'($urandom_range(63));
    it.code   = pfxd_pkg::CODE_W'($urandom);
    it.data   = pfxd_pkg::BYTE_W'($urandom_range(255));
    return it;
  endfunction

  // one input transfer, with a random idle gap in front
  task automatic send_item(input dec_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= it.op;
    in_ch.entry_index  <= it.index;
    in_ch.entry_symbol <= it.symbol;
    in_ch.entry_length <= it.length;
    in_ch.entry_code   <= it.code;
    in_ch.data_byte    <= it.data;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    decode_item(it);
    items_sent++;
  endtask

  task automatic send_load(input int idx, input int sym, input int len, input logic [31:0] code);
    dec_item_t it;
    it        = random_item(pfxd_pkg::OP_LOAD);
    it.index  = 8'(idx);
    it.symbol = pfxd_pkg::SYM_W'(sym);
    it.length = pfxd_pkg::LEN_W'(len);
    it.code   = code;
    send_item(it);
  endtask

  task automatic send_data(input logic [7:0] value);
    dec_item_t it;
    it      = random_item(pfxd_pkg::OP_DATA);
    it.data = value;
    send_item(it);
  endtask

  // result checker
  always @(posedge clk) begin
    dec_result_t exp_r;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d symbol %0h",
                                  out_ch.kind, out_ch.symbol));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.kind !== exp_r.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_ch.kind, exp_r.kind));
        if (out_ch.symbol !== exp_r.symbol)
          report_mismatch($sformatf("symbol %0h, expected %0h", out_ch.symbol, exp_r.symbol));
        if (out_ch.last !== exp_r.last)
          report_mismatch($sformatf("last %0d, expected %0d", out_ch.last, exp_r.last));
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // every data bit overflows while the table is empty
  task automatic test_empty_table();
    send_data(8'hFF);
    send_item(random_item(OP_UNKNOWN));
  endtask

  // stray code bits, lowest index wins, over-long codes ignored
  task automatic test_match_priority();
    send_load(0, 8'hA5, 1, 32'hFFFF_FFFE);
    send_load(255, 8'hFF, 1, 32'h0000_0000);
    send_load(1, 8'h3C, 2, 32'h0000_0003);
    send_data(8'h60);
    send_load(2, 8'h77, 33, 32'hFFFF_FFFF);
    send_load(3, 8'h11, 63, 32'h0000_0000);
    send_data(8'hFF);
  endtask

  // full-width code, then overflow past it leaving a partial code behind
  task automatic test_long_code();
    send_item(random_item(pfxd_pkg::OP_CLEAR));
    send_load(128, 8'hEE, pfxd_pkg::MAX_CODE_LEN, 32'hFFFF_FFFF);
    repeat (4) send_data(8'hFF);
    repeat (5) send_data(8'h00);
  endtask

  // a zero length leaves the slot unused
  task automatic test_unused_slot();
    send_item(random_item(pfxd_pkg::OP_CLEAR));
    send_load(5, 8'h5A, 0, 32'hDEAD_BEEF);
    send_data(8'h00);
  endtask

  // one session: build a prefix code tree, load it, then stream coded bytes
  task automatic run_code_session();
    logic [31:0] lf_code[$];
    int          lf_len[$];
    bit          used_idx[pfxd_pkg::TABLE_ENTRIES];
    bit          stream_bits[$];
    bit          skew;
    int          leaves;
    int          pick;
    int          drop;
    int          idx;
    int          n_data;
    logic [31:0] c;
    logic [7:0]  value;
    dec_item_t   it;
    skew   = ($urandom_range(3) == 0);
    leaves = skew ? $urandom_range(8, 33) : $urandom_range(2, 20);
    lf_code.push_back('0);
    lf_len.push_back(0);
    foreach (used_idx[i]) used_idx[i] = 1'b0;
    // split leaves until the tree is big enough
    while (lf_len.size() < leaves) begin
      pick = $urandom_range(lf_len.size() - 1);
      if (skew)
        foreach (lf_len[i]) if (lf_len[i] > lf_len[pick]) pick = i;
      if (lf_len[pick] >= pfxd_pkg::MAX_CODE_LEN) break;
      c = lf_code[pick];
      lf_code[pick] = c << 1;
      lf_len[pick]  = lf_len[pick] + 1;
      lf_code.push_back((c << 1) | 32'd1);
      lf_len.push_back(lf_len[pick]);
    end
    if ($urandom_range(4) != 0) send_item(random_item(pfxd_pkg::OP_CLEAR));
    // sometimes leave one code out so the stream breaks
    drop = ($urandom_range(3) == 0) ? $urandom_range(lf_len.size() - 1) : -1;
    foreach (lf_len[i]) begin
      if (i != drop) begin
        do idx = $urandom_range(pfxd_pkg::TABLE_ENTRIES - 1); while (used_idx[idx]);
        used_idx[idx] = 1'b1;
        it        = random_item(pfxd_pkg::OP_LOAD);
        it.index  = 8'(idx);
        it.length = pfxd_pkg::LEN_W'(lf_len[i]);
        it.code   = lf_code[i];
        if (lf_len[i] < 32 && $urandom_range(3) == 0)
          it.code = lf_code[i] | (pfxd_pkg::CODE_W'($urandom) << lf_len[i]);
        send_item(it);
      end
      // noise between loads
      if ($urandom_range(9) == 0)
        send_item(random_item($urandom_range(1) ? pfxd_pkg::OP_LOAD : OP_UNKNOWN));
    end
    n_data = $urandom_range(6, 16);
    repeat (n_data) begin
      if ($urandom_range(3) != 0) begin
        while (stream_bits.size() < 8) begin
          pick = $urandom_range(lf_len.size() - 1);
          for (int j = lf_len[pick] - 1; j >= 0; j--) stream_bits.push_back(lf_code[pick][j]);
        end
        for (int j = 7; j >= 0; j--) value[j] = stream_bits.pop_front();
      end else begin
        value = 8'($urandom_range(255));
      end
      send_data(value);
    end
  endtask

  task automatic test_random_stream(input int send_pct, input int recv_pct, input int n_items);
    int start;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < n_items) run_code_session();
  endtask

  // main sequence
  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= pfxd_pkg::OP_CLEAR;
    in_ch.entry_index  <= '0;
    in_ch.entry_symbol <= '0;
    in_ch.entry_length <= '0;
    in_ch.entry_code   <= '0;
    in_ch.data_byte    <= '0;
    clear_code_table();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_match_priority();
    test_long_code();
    test_unused_slot();
    test_random_stream(0, 0, 65);
    test_random_stream(71, 0, 65);
    test_random_stream(0, 71, 65);
    test_random_stream(23, 23, 65);
    in_ch.valid <= 1'b0;
    send_idle_pct  = 0;

    // drain, then let a last data byte finish
    while (pending_results.size() != 0) @(posedge clk);
    repeat (BYTE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
